// ----- sv/date_add_days_unit_assert.svh -----
// assertion macros used by the port-level checker file
`ifndef DATE_ADD_DAYS_UNIT_ASSERT_SVH
`define DATE_ADD_DAYS_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define DAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("date adder check failed");

// next-cycle implication, disabled while reset is low
`define DAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("date adder check failed");

`endif

// ----- sv/dau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_pkg
// types, codes and calendar helpers of the microcoded date adder
// ----------------------------------------------------------------------------
package dau_pkg;

  localparam int unsigned STEP_W = 3;

  // microcode addresses
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_RED   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_CLAMP = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LOOP  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DONE  = 3'd4;

  localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
  localparam logic [8:0]  DAYS_YEAR      = 9'd365;
  localparam logic [8:0]  CYCLE_400      = 9'd400;
  localparam logic [8:0]  LAST_IN_CYCLE  = 9'd399;
  localparam logic [8:0]  CENTURY_1      = 9'd100;
  localparam logic [8:0]  CENTURY_2      = 9'd200;
  localparam logic [8:0]  CENTURY_3      = 9'd300;
  localparam logic [4:0]  FEB_LEAP_DAYS  = 5'd29;
  localparam logic [4:0]  FEB_DAYS       = 5'd28;
  localparam logic [3:0]  MONTH_JAN      = 4'd1;
  localparam logic [3:0]  MONTH_FEB      = 4'd2;
  localparam logic [3:0]  MONTH_DEC      = 4'd12;
  localparam logic [15:0] YEAR_MAX       = 16'hFFFF;
  localparam logic [2:0]  RED_STEPS_LAST = 3'd7;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED,
    OP_CLAMP,
    OP_ADV,
    OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_SH_NZ,
    COND_K_NZ,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e                op;
    cond_e              cond;
    logic [STEP_W-1:0]  jump;
    logic [STEP_W-1:0]  next;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic sh_nz;
    logic k_nz;
    logic out_busy;
  } status_t;

  // leap test from the two low year bits and the year modulo 400
  function automatic logic is_leap(input logic [1:0] y_lo, input logic [8:0] r400);
    return (r400 == '0) ||
           ((y_lo == 2'd0) && (r400 != CENTURY_1) && (r400 != CENTURY_2) &&
            (r400 != CENTURY_3));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MONTH_FEB:                   len = leap ? FEB_LEAP_DAYS : FEB_DAYS;
      4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
      default:                     len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- sv/dau_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_if
// valid/ready channels of the date adder: start date in, end date out
// ----------------------------------------------------------------------------
interface dau_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  start_day;
  logic [3:0]  start_month;
  logic [15:0] start_year;
  logic [15:0] days_to_add;

  modport source (output valid, start_day, start_month, start_year, days_to_add,
                  input ready);
  modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                  output ready);
endinterface

interface dau_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  end_day;
  logic [3:0]  end_month;
  logic [15:0] end_year;
  logic        year_overflow;

  modport source (output valid, end_day, end_month, end_year, year_overflow,
                  input ready);
  modport sink   (input valid, end_day, end_month, end_year, year_overflow,
                  output ready);
endinterface

// ----- sv/dau_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_rom
// microcode store: one control word per step
// ----------------------------------------------------------------------------
module dau_rom (
  input  logic [dau_pkg::STEP_W-1:0] step_i,
  output dau_pkg::ctrl_word_t        word_o
);

  always_comb begin
    unique case (step_i)
      dau_pkg::STEP_IDLE: begin
        word_o = '{dau_pkg::OP_LOAD, dau_pkg::COND_IN_VALID,
                   dau_pkg::STEP_RED, dau_pkg::STEP_IDLE};
      end
      dau_pkg::STEP_RED: begin
        word_o = '{dau_pkg::OP_RED, dau_pkg::COND_SH_NZ,
                   dau_pkg::STEP_RED, dau_pkg::STEP_CLAMP};
      end
      dau_pkg::STEP_CLAMP: begin
        word_o = '{dau_pkg::OP_CLAMP, dau_pkg::COND_ALWAYS,
                   dau_pkg::STEP_LOOP, dau_pkg::STEP_LOOP};
      end
      dau_pkg::STEP_LOOP: begin
        word_o = '{dau_pkg::OP_ADV, dau_pkg::COND_K_NZ,
                   dau_pkg::STEP_LOOP, dau_pkg::STEP_DONE};
      end
      dau_pkg::STEP_DONE: begin
        word_o = '{dau_pkg::OP_OUT, dau_pkg::COND_OUT_BUSY,
                   dau_pkg::STEP_DONE, dau_pkg::STEP_IDLE};
      end
      default: begin
        word_o = '{dau_pkg::OP_NONE, dau_pkg::COND_ALWAYS,
                   dau_pkg::STEP_IDLE, dau_pkg::STEP_IDLE};
      end
    endcase
  end

endmodule

// ----- sv/dau_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_seq
// step counter with conditional jumps over the microcode store
// ----------------------------------------------------------------------------
module dau_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dau_pkg::status_t stat_i,
  output dau_pkg::op_e     op_o,
  output logic             idle_o
);

  logic [dau_pkg::STEP_W-1:0] step_q, step_d;
  dau_pkg::ctrl_word_t        word;
  logic                       take;

  dau_rom u_rom (
    .step_i (step_q),
    .word_o (word)
  );

  always_comb begin
    case (word.cond)
      dau_pkg::COND_ALWAYS:   take = 1'b1;
      dau_pkg::COND_IN_VALID: take = stat_i.in_valid;
      dau_pkg::COND_SH_NZ:    take = stat_i.sh_nz;
      dau_pkg::COND_K_NZ:     take = stat_i.k_nz;
      dau_pkg::COND_OUT_BUSY: take = stat_i.out_busy;
      default:                take = 1'b1;
    endcase
    step_d = take ? word.jump : word.next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= dau_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign op_o   = word.op;
  assign idle_o = (step_q == dau_pkg::STEP_IDLE);

endmodule

// ----- sv/dau_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_dpath
// date registers, year-mod-400 tracker and output register
// ----------------------------------------------------------------------------
module dau_dpath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dau_pkg::op_e     op_i,
  input  logic [4:0]       start_day_i,
  input  logic [3:0]       start_month_i,
  input  logic [15:0]      start_year_i,
  input  logic [15:0]      days_to_add_i,
  input  logic             out_ready_i,
  output dau_pkg::status_t stat_o,
  output logic             out_valid_o,
  output logic [4:0]       end_day_o,
  output logic [3:0]       end_month_o,
  output logic [15:0]      end_year_o,
  output logic             year_overflow_o
);

  logic [4:0]  d_q, d_d;
  logic [3:0]  m_q, m_d;
  logic [15:0] y_q, y_d;
  logic [15:0] k_q, k_d;
  logic [15:0] r_q, r_d;
  logic [2:0]  sh_q, sh_d;
  logic        ovf_q, ovf_d;
  logic        ov_q, ov_d;
  logic [4:0]  od_q;
  logic [3:0]  om_q;
  logic [15:0] oy_q;
  logic        oovf_q;

  logic        leap;
  logic [4:0]  dim;
  logic [8:0]  diy;
  logic [4:0]  rem;
  logic [16:0] red_cmp;
  logic        out_busy;
  logic        year_ok;
  logic [15:0] yb;
  logic [15:0] rb;
  logic        ovfb;

  assign leap     = dau_pkg::is_leap(y_q[1:0], r_q[8:0]);
  assign dim      = dau_pkg::month_len(m_q, leap);
  assign diy      = leap ? dau_pkg::DAYS_LEAP_YEAR : dau_pkg::DAYS_YEAR;
  assign rem      = dim - d_q;
  assign red_cmp  = {8'd0, dau_pkg::CYCLE_400} << sh_q;
  assign out_busy = ov_q && !out_ready_i;
  assign year_ok  = (d_q == 5'd1) && (m_q == dau_pkg::MONTH_JAN) && (k_q >= {7'd0, diy});

  // year plus one, with wrap and mod-400 tracking
  always_comb begin
    if (y_q == dau_pkg::YEAR_MAX) begin
      yb   = '0;
      rb   = '0;
      ovfb = 1'b1;
    end else begin
      yb   = y_q + 16'd1;
      rb   = (r_q[8:0] == dau_pkg::LAST_IN_CYCLE) ? 16'd0 : r_q + 16'd1;
      ovfb = ovf_q;
    end
  end

  always_comb begin
    d_d   = d_q;
    m_d   = m_q;
    y_d   = y_q;
    k_d   = k_q;
    r_d   = r_q;
    sh_d  = sh_q;
    ovf_d = ovf_q;
    ov_d  = ov_q && !out_ready_i;
    case (op_i)
      dau_pkg::OP_LOAD: begin
        d_d   = (start_day_i == 5'd0) ? 5'd1 : start_day_i;
        if (start_month_i == 4'd0) begin
          m_d = dau_pkg::MONTH_JAN;
        end else if (start_month_i > dau_pkg::MONTH_DEC) begin
          m_d = dau_pkg::MONTH_DEC;
        end else begin
          m_d = start_month_i;
        end
        y_d   = start_year_i;
        k_d   = days_to_add_i;
        r_d   = start_year_i;
        sh_d  = dau_pkg::RED_STEPS_LAST;
        ovf_d = 1'b0;
      end
      dau_pkg::OP_RED: begin
        // restoring reduction of the year modulo 400
        if ({1'b0, r_q} >= red_cmp) begin
          r_d = r_q - red_cmp[15:0];
        end
        sh_d = sh_q - 3'd1;
      end
      dau_pkg::OP_CLAMP: begin
        if (d_q > dim) begin
          d_d = dim;
        end
      end
      dau_pkg::OP_ADV: begin
        if (year_ok) begin
          k_d   = k_q - {7'd0, diy};
          y_d   = yb;
          r_d   = rb;
          ovf_d = ovfb;
        end else if (k_q <= {11'd0, rem}) begin
          d_d = d_q + k_q[4:0];
          k_d = '0;
        end else begin
          k_d = k_q - ({11'd0, rem} + 16'd1);
          d_d = 5'd1;
          if (m_q == dau_pkg::MONTH_DEC) begin
            m_d   = dau_pkg::MONTH_JAN;
            y_d   = yb;
            r_d   = rb;
            ovf_d = ovfb;
          end else begin
            m_d = m_q + 4'd1;
          end
        end
      end
      dau_pkg::OP_OUT: begin
        if (!out_busy) begin
          ov_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    m_q   <= m_d;
    y_q   <= y_d;
    k_q   <= k_d;
    r_q   <= r_d;
    sh_q  <= sh_d;
    ovf_q <= ovf_d;
    if (op_i == dau_pkg::OP_OUT && !out_busy) begin
      od_q   <= d_q;
      om_q   <= m_q;
      oy_q   <= y_q;
      oovf_q <= ovf_q;
    end
  end

  assign stat_o.in_valid = 1'b0;
  assign stat_o.sh_nz    = (sh_q != 3'd0);
  assign stat_o.k_nz     = (k_q != 16'd0);
  assign stat_o.out_busy = out_busy;

  assign out_valid_o     = ov_q;
  assign end_day_o       = od_q;
  assign end_month_o     = om_q;
  assign end_year_o      = oy_q;
  assign year_overflow_o = oovf_q;

endmodule

// ----- sv/date_add_days_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_days_unit
// gregorian date plus a day offset, run by a small microcode program
// ----------------------------------------------------------------------------
// usage
//   in_i carries a word of start day, month, year and a 16-bit day offset;
//   it is taken when valid and ready are both high. out_o returns one word
//   per input: end day, month, year (mod 65536) and a year overflow flag.
//   ready on in_i is high only while the sequencer sits in its idle step,
//   so one word is worked on at a time.
// sequence
//   the word is loaded, the year is reduced modulo 400, the day is
//   clamped, then whole years or months are stepped, then the days left,
//   then a closing step, and the result goes into the output register.
//   the year/month stepping loop sets the run time.
// stall
//   the result sits in an output register; the next word is accepted while
//   it waits. a finished second result holds in the done step until the
//   receiver takes the first one.
// reset
//   asynchronous, active low: sequencer back to idle, output valid cleared.
// ----------------------------------------------------------------------------
module date_add_days_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  dau_in_if.sink     in_i,
  dau_out_if.source  out_o
);

  dau_pkg::op_e     op;
  dau_pkg::status_t dp_stat;
  dau_pkg::status_t seq_stat;
  logic             idle;

  // sequencer: step counter, microcode store and jump conditions
  dau_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (seq_stat),
    .op_o   (op),
    .idle_o (idle)
  );

  // the input valid joins the datapath status for the idle-step jump
  always_comb begin
    seq_stat          = dp_stat;
    seq_stat.in_valid = in_i.valid;
  end

  assign in_i.ready = idle;

  // datapath: date registers, offset counter, output register
  dau_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .start_day_i     (in_i.start_day),
    .start_month_i   (in_i.start_month),
    .start_year_i    (in_i.start_year),
    .days_to_add_i   (in_i.days_to_add),
    .out_ready_i     (out_o.ready),
    .stat_o          (dp_stat),
    .out_valid_o     (out_o.valid),
    .end_day_o       (out_o.end_day),
    .end_month_o     (out_o.end_month),
    .end_year_o      (out_o.end_year),
    .year_overflow_o (out_o.year_overflow)
  );

endmodule

// ----- sv/dau_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_checker
// port-level checks of the date adder, bound to the top level
// ----------------------------------------------------------------------------
`include "date_add_days_unit_assert.svh"

module dau_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  end_day_i,
  input logic [3:0]  end_month_i,
  input logic [15:0] end_year_i
);

  logic legal_date;

  assign legal_date = (end_day_i != 5'd0) && (end_month_i != 4'd0) &&
                      (end_month_i <= 4'd12);

  // a stalled result stays valid
  `DAU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // a stalled result keeps its year
  `DAU_ASSERT_NXT(a_year_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(end_year_i))

  // one word at a time: ready drops right after an accept
  `DAU_ASSERT_NXT(a_one_busy, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // results are always a legal day and month
  `DAU_ASSERT_IMP(a_legal_date, clk_i, rst_ni, out_valid_i, legal_date)

endmodule

bind date_add_days_unit dau_checker u_dau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .end_day_i   (out_o.end_day),
  .end_month_i (out_o.end_month),
  .end_year_i  (out_o.end_year)
);

// ----- tb/date_add_days_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_days_checker
// watches both date channels, works out the end date of every accepted
// start word and compares each returned word with the oldest one due
// ----------------------------------------------------------------------------
module date_add_days_checker (
  input  logic clk_i,
  input  logic rst_ni,
  dau_in_if    date_in_i,
  dau_out_if   date_out_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        ovf;
  } cal_date_t;

  cal_date_t end_dates_q[$];

  function automatic bit leap_yr(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_of_month(input int unsigned m, input int unsigned y);
    int unsigned len;
    case (m)
      dau_pkg::MONTH_FEB: len = leap_yr(y) ? 29 : 28;
      4, 6, 9, 11:        len = 30;
      default:            len = 31;
    endcase
    return len;
  endfunction

  // whole years from jan 1, then whole months, then the days left
  function automatic cal_date_t advance_date(input logic [4:0] d_in, input logic [3:0] m_in,
                                             input logic [15:0] y_in, input logic [15:0] k_in);
    int unsigned d, m, y, k, mlen, ylen;
    bit          wrap;
    cal_date_t   r;
    d    = d_in;
    m    = m_in;
    y    = y_in;
    k    = k_in;
    wrap = 1'b0;
    if (m < dau_pkg::MONTH_JAN) m = dau_pkg::MONTH_JAN;
    if (m > dau_pkg::MONTH_DEC) m = dau_pkg::MONTH_DEC;
    if (d < 1) d = 1;
    mlen = days_of_month(m, y);
    if (d > mlen) d = mlen;
    while (k > 0) begin
      ylen = leap_yr(y) ? 366 : 365;
      mlen = days_of_month(m, y);
      if (d == 1 && m == dau_pkg::MONTH_JAN && k >= ylen) begin
        k -= ylen;
        wrap |= (y == dau_pkg::YEAR_MAX);
        y = (y == dau_pkg::YEAR_MAX) ? 0 : y + 1;
      end else if (k <= mlen - d) begin
        d += k;
        k = 0;
      end else begin
        k -= mlen - d + 1;
        d = 1;
        if (m == dau_pkg::MONTH_DEC) begin
          m = dau_pkg::MONTH_JAN;
          wrap |= (y == dau_pkg::YEAR_MAX);
          y = (y == dau_pkg::YEAR_MAX) ? 0 : y + 1;
        end else begin
          m++;
        end
      end
    end
    r.day   = d[4:0];
    r.month = m[3:0];
    r.year  = y[15:0];
    r.ovf   = wrap;
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    cal_date_t want;
    cal_date_t got;
    int        errs;
    errs = 0;
    if (rst_ni) begin
      if (date_in_i.valid && date_in_i.ready)
        end_dates_q.push_back(advance_date(date_in_i.start_day, date_in_i.start_month,
                                           date_in_i.start_year, date_in_i.days_to_add));
      if (date_out_i.valid && date_out_i.ready) begin
        got = {date_out_i.end_day, date_out_i.end_month, date_out_i.end_year,
               date_out_i.year_overflow};
        if (end_dates_q.size() == 0) begin
          $error("end date word %0d/%0d/%0d with no start date waiting",
                 got.day, got.month, got.year);
          errs++;
        end else begin
          want = end_dates_q.pop_front();
          if (got.day !== want.day) begin
            $error("end_day: expected %0d, got %0d", want.day, got.day);
            errs++;
          end
          if (got.month !== want.month) begin
            $error("end_month: expected %0d, got %0d", want.month, got.month);
            errs++;
          end
          if (got.year !== want.year) begin
            $error("end_year: expected %0d, got %0d", want.year, got.year);
            errs++;
          end
          if (got.ovf !== want.ovf) begin
            $error("year_overflow: expected %0d, got %0d", want.ovf, got.ovf);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= end_dates_q.size();
    end
  end

endmodule

// ----- tb/date_add_days_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_days_unit_tb
// drives start dates with day offsets into the date adder: a directed set
// of calendar corner cases, then random words, with random gaps on both
// channels; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module date_add_days_unit_tb;

  localparam int N_DIR        = 24;
  localparam int N_RAND       = 650;
  localparam int N_WORDS      = N_DIR + N_RAND;
  localparam int PAUSE_AT     = 200;      // sender drains the block after this word
  localparam int BURST_LO     = 400;      // words sent back to back
  localparam int BURST_HI     = 480;
  localparam int HOLD_AT      = 150;      // receiver goes quiet after this many results
  localparam int HOLD_LEN     = 500;
  localparam int RX_OPEN_LO   = 450;      // receiver never stalls in this stretch
  localparam int RX_OPEN_HI   = 520;
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT  = 1500000;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [15:0] days;
  } start_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   n_failed;
  int   n_due;
  int   cycle_cnt = 0;

  // receiver state
  int   taken_cnt = 0;
  int   rx_gap    = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  dau_in_if  date_in ();
  dau_out_if date_out ();

  date_add_days_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (date_in),
    .out_o  (date_out)
  );

  date_add_days_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .date_in_i    (date_in),
    .date_out_i   (date_out),
    .fail_count_o (n_failed),
    .pending_o    (n_due)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // calendar corner cases: day, month, year, offset
  start_word_t dir_words [N_DIR] = '{
    {5'd1,  4'd1,  16'd2024,  16'd0},      // zero offset
    {5'd0,  4'd0,  16'd0,     16'd0},      // day zero and month zero fixed up
    {5'd31, 4'd15, 16'd65535, 16'd0},      // month above december
    {5'd31, 4'd13, 16'd100,   16'd1},      // month 13 as december, into next year
    {5'd30, 4'd2,  16'd1900,  16'd0},      // past end of february, century non-leap
    {5'd29, 4'd2,  16'd2000,  16'd0},      // leap day in a 400 year
    {5'd31, 4'd4,  16'd2023,  16'd0},      // day 31 of a 30-day month
    {5'd28, 4'd2,  16'd1900,  16'd1},
    {5'd28, 4'd2,  16'd2000,  16'd1},
    {5'd1,  4'd1,  16'd2000,  16'd366},    // whole leap year
    {5'd1,  4'd1,  16'd2001,  16'd365},    // whole common year
    {5'd1,  4'd1,  16'd0,     16'd65535},  // year zero is leap, largest offset
    {5'd31, 4'd12, 16'd65535, 16'd1},      // year wraps on new year
    {5'd1,  4'd1,  16'd65500, 16'd65535},  // wrap while stepping years
    {5'd31, 4'd1,  16'd65535, 16'd65535},
    {5'd15, 4'd6,  16'd32768, 16'd12345},
    {5'd31, 4'd1,  16'd2023,  16'd29},
    {5'd1,  4'd3,  16'd2024,  16'd65535},
    {5'd29, 4'd2,  16'd2400,  16'd365},
    {5'd1,  4'd1,  16'd2100,  16'd365},
    {5'd0,  4'd1,  16'd0,     16'd1},
    {5'd31, 4'd8,  16'd1999,  16'd153},
    {5'd1,  4'd1,  16'd65535, 16'd366},    // odd year, wraps to year zero
    {5'd17, 4'd11, 16'd4095,  16'd40000}
  };

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  // offer one word and hold it until taken, then drop valid for the given gap
  task automatic send_word(input start_word_t w, input int gap);
    date_in.valid       <= 1'b1;
    date_in.start_day   <= w.day;
    date_in.start_month <= w.month;
    date_in.start_year  <= w.year;
    date_in.days_to_add <= w.days;
    do @(posedge clk_i); while (!date_in.ready);
    if (gap > 0) begin
      date_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off so the block backs up, and
  // one stretch with ready held high
  always @(posedge clk_i) begin
    if (date_out.valid && date_out.ready) taken_cnt <= taken_cnt + 1;
    if (hold_left > 0) begin
      date_out.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (!hold_done && taken_cnt == HOLD_AT) begin
      date_out.ready <= 1'b0;
      hold_done      <= 1'b1;
      hold_left      <= HOLD_LEN;
    end else if (taken_cnt >= RX_OPEN_LO && taken_cnt < RX_OPEN_HI) begin
      date_out.ready <= 1'b1;
    end else if (rx_gap > 0) begin
      date_out.ready <= 1'b0;
      rx_gap         <= rx_gap - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      date_out.ready <= 1'b0;
      rx_gap         <= pick_gap() - 1;
    end else begin
      date_out.ready <= 1'b1;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    date_in.valid       = 1'b0;
    date_in.start_day   = '0;
    date_in.start_month = '0;
    date_in.start_year  = '0;
    date_in.days_to_add = '0;
    date_out.ready      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_WORDS; i++) begin
      start_word_t w;
      int          gap;
      if (i < N_DIR) begin
        w = dir_words[i];
      end else begin
        case ($urandom_range(0, 6))
          0: begin  // any bit pattern, out-of-range day and month included
            w.day   = 5'($urandom_range(0, 31));
            w.month = 4'($urandom_range(0, 15));
            w.year  = 16'($urandom);
            w.days  = 16'($urandom);
          end
          1, 2: begin  // plain valid date, any offset
            w.day   = 5'($urandom_range(1, 28));
            w.month = 4'($urandom_range(1, 12));
            w.year  = 16'($urandom);
            w.days  = 16'($urandom);
          end
          3: begin  // month ends, short offsets across the boundary
            w.day   = 5'($urandom_range(28, 31));
            w.month = 4'($urandom_range(1, 12));
            w.year  = 16'($urandom);
            w.days  = 16'($urandom_range(0, 800));
          end
          4: begin  // new year's day, so whole years get stepped
            w.day   = 5'd1;
            w.month = 4'd1;
            w.year  = 16'($urandom);
            w.days  = 16'($urandom);
          end
          5: begin  // close to the top year, wrap likely
            w.day   = 5'($urandom_range(1, 31));
            w.month = 4'($urandom_range(1, 12));
            w.year  = 16'(16'hFFFF - $urandom_range(0, 250));
            w.days  = 16'($urandom);
          end
          default: begin  // century years around february
            w.day   = 5'($urandom_range(1, 29));
            w.month = 4'($urandom_range(1, 3));
            w.year  = 16'(100 * $urandom_range(0, 655));
            w.days  = 16'($urandom_range(0, 1500));
          end
        endcase
      end
      // valid must drop before the drain pause and after the last word
      if (i == PAUSE_AT || i == N_WORDS - 1) gap = 1;
      else if (i >= BURST_LO && i < BURST_HI) gap = 0;
      else if ($urandom_range(0, 1) == 0) gap = 0;
      else gap = pick_gap();
      send_word(w, gap);
      if (i == PAUSE_AT) begin
        do @(posedge clk_i); while (n_due != 0);
      end
    end

    do @(posedge clk_i); while (n_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_failed == 0 && n_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/dau_pkg.sv
sv/dau_if.sv
sv/dau_rom.sv
sv/dau_seq.sv
sv/dau_dpath.sv
sv/date_add_days_unit.sv
sv/dau_checker.sv
tb/date_add_days_checker.sv
tb/date_add_days_unit_tb.sv
